>>> design/deq_pkg.sv
// deq_pkg: shared types and codes for the indexed double-ended queue.
// Holds request and result word structs, operation and status codes.
// No dependencies.
`timescale 1ns / 1ps

package deq_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned INDEX_W = 16;
	localparam int unsigned COUNT_W = 17;

	typedef enum logic [2:0] {
		OP_PUSH_BACK    = 3'd0,
		OP_PUSH_FRONT   = 3'd1,
		OP_REMOVE_BACK  = 3'd2,
		OP_REMOVE_FRONT = 3'd3,
		OP_READ         = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]                operation;
		logic signed [VALUE_W-1:0] value;
		logic [INDEX_W-1:0]        index;
	} req_t;

	typedef struct packed {
		logic [1:0]                status;
		logic signed [VALUE_W-1:0] read_value;
		logic [COUNT_W-1:0]        count_now;
	} rsp_t;

endpackage

>>> design/deq_mem.sv
// deq_mem: element store of the double-ended queue.
// One write port and one read port, read data registered.
// Depends on deq_pkg for the element width.
`timescale 1ns / 1ps

module deq_mem #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [AW-1:0]                       waddr,
	input  logic signed [deq_pkg::VALUE_W-1:0]  wdata,
	input  logic                                re,
	input  logic [AW-1:0]                       raddr,
	output logic signed [deq_pkg::VALUE_W-1:0]  rdata
);

	logic [deq_pkg::VALUE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> design/double_ended_queue_indexed.sv
// double_ended_queue_indexed: bounded deque of signed 32-bit words with indexed read.
// Holds the front and count registers, address logic and result stage.
// Depends on deq_pkg and deq_mem.
//
// Usage:
//   A request word (operation, value, index) is taken at a rising edge with start
//   high and busy low. busy stays low: a request may be issued every cycle.
//   Exactly one result word (status, read_value, count_now) follows on result,
//   marked by done for one cycle, at the edge after the request is taken.
//   read_value comes from the registered read port of the element store;
//   throughput is one request per cycle. Pushes write the store at the accept
//   edge, so a read issued in the next cycle already sees the new word.
//   Reset clears front position and count; store contents stay undefined, but
//   only entries written by a push are ever read.
//   The receiver cannot stall: each result is valid for its one done cycle only.
//   Full pushes are dropped (status full), removals from an empty queue report
//   empty, reads at or past the count report out of range; read_value is zero
//   except on a successful read.
`timescale 1ns / 1ps

module double_ended_queue_indexed #(
	parameter int unsigned DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  deq_pkg::req_t  request,
	output logic           busy,
	output logic           done,
	output deq_pkg::rsp_t  result
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned SW = deq_pkg::COUNT_W + 1;
	localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
	localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);

	logic [AW-1:0] front_q;
	logic [CW-1:0] count_q;
	logic          done_q;
	logic [1:0]    status_s1;
	logic          rd_en_s1;

	logic          accept;
	logic          full;
	logic          empty;
	logic          in_range;
	logic [SW-1:0] sum;
	logic [SW-1:0] sum_wrap;
	logic [AW-1:0] addr;
	logic [AW-1:0] front_dec;
	logic [AW-1:0] front_inc;

	logic [AW-1:0] front_d;
	logic [CW-1:0] count_d;
	logic [1:0]    status_d;
	logic          we;
	logic [AW-1:0] waddr;
	logic          re;

	logic signed [deq_pkg::VALUE_W-1:0] rdata;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign in_range = deq_pkg::COUNT_W'(request.index) < deq_pkg::COUNT_W'(count_q);

	assign sum = SW'(front_q) +
		((request.operation == deq_pkg::OP_PUSH_BACK) ? SW'(count_q) : SW'(request.index));
	assign sum_wrap = (sum >= DEPTH_S) ? (sum - DEPTH_S) : sum;
	assign addr     = sum_wrap[AW-1:0];

	assign front_dec = (front_q == '0) ? LAST_POS : (front_q - AW'(1));
	assign front_inc = (front_q == LAST_POS) ? '0 : (front_q + AW'(1));

	always_comb begin
		front_d  = front_q;
		count_d  = count_q;
		status_d = deq_pkg::ST_OK;
		we       = 1'b0;
		waddr    = addr;
		re       = 1'b0;
		unique case (request.operation)
			deq_pkg::OP_PUSH_BACK: begin
				if (full) begin
					status_d = deq_pkg::ST_FULL;
				end else begin
					we      = 1'b1;
					count_d = count_q + CW'(1);
				end
			end
			deq_pkg::OP_PUSH_FRONT: begin
				waddr = front_dec;
				if (full) begin
					status_d = deq_pkg::ST_FULL;
				end else begin
					we      = 1'b1;
					front_d = front_dec;
					count_d = count_q + CW'(1);
				end
			end
			deq_pkg::OP_REMOVE_BACK: begin
				if (empty) begin
					status_d = deq_pkg::ST_EMPTY;
				end else begin
					count_d = count_q - CW'(1);
				end
			end
			deq_pkg::OP_REMOVE_FRONT: begin
				if (empty) begin
					status_d = deq_pkg::ST_EMPTY;
				end else begin
					front_d = front_inc;
					count_d = count_q - CW'(1);
				end
			end
			deq_pkg::OP_READ: begin
				if (!in_range) begin
					status_d = deq_pkg::ST_RANGE;
				end else begin
					re = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q  <= '0;
			count_q  <= '0;
			done_q   <= 1'b0;
			rd_en_s1 <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				front_q  <= front_d;
				count_q  <= count_d;
				rd_en_s1 <= re;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
		end
	end

	deq_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (accept && we),
		.waddr (waddr),
		.wdata (request.value),
		.re    (accept && re),
		.raddr (addr),
		.rdata (rdata)
	);

	assign done              = done_q;
	assign result.status     = status_s1;
	assign result.read_value = rd_en_s1 ? rdata : '0;
	assign result.count_now  = deq_pkg::COUNT_W'(count_q);

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("element count exceeds depth");

	a_front_bound: assert property (@(posedge clk) disable iff (!arst_n)
		front_q <= LAST_POS)
		else $error("front position outside store");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("result word missing after request");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == deq_pkg::ST_FULL |-> result.count_now == deq_pkg::COUNT_W'(DEPTH))
		else $error("push dropped while not full");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == deq_pkg::ST_EMPTY |-> result.count_now == '0)
		else $error("removal refused while not empty");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != deq_pkg::ST_OK |-> result.read_value == '0)
		else $error("nonzero read value on failed request");
`endif

endmodule
